// ----- rtl/core/bba_pkg.sv -----
// Buddy block allocator: shared constants, codes and the configuration record.
// Used by bba_engine and buddy_block_allocator_core; depends on nothing.
`timescale 1ns / 1ps

package bba_pkg;

  // Default geometry (MIN_BLOCK_BYTES must be a power of two)
  localparam int MaxOrderDef      = 4;
  localparam int TopBlocksDef     = 16;
  localparam int MinBlockBytesDef = 4096;
  localparam int ZonesDef         = 2;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_DMA_BLOCKS    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NORMAL_BLOCKS = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_NORMAL_BASE   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_PROT_START    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_PROT_END      = 3'd4;

  // Reset values of the configuration registers
  localparam logic [4:0]  DMA_BLOCKS_RST    = 5'd16;
  localparam logic [4:0]  NORMAL_BLOCKS_RST = 5'd16;
  localparam logic [31:0] NORMAL_BASE_RST   = 32'h0100_0000;

  // Request kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_RESERVE = 2'd2;
  localparam logic [1:0] KIND_INIT    = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [1:0] ST_NO_FREE  = 2'd2;
  localparam logic [1:0] ST_PROTECT  = 2'd3;

  typedef struct packed {
    logic [4:0]  dma_top_blocks;
    logic [4:0]  normal_top_blocks;
    logic [31:0] normal_zone_base;
    logic [31:0] protect_start;
    logic [31:0] protect_end;
  } cfg_t;

endpackage

// ----- rtl/core/bba_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package needed.
`timescale 1ns / 1ps

module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bba_engine.sv -----
// Allocator sequencer: read-modify-write of the block bitmap RAM and the
// per-order count/hint RAM. Depends on bba_pkg.
`timescale 1ns / 1ps

module bba_engine import bba_pkg::*; #(
  parameter int MAX_ORDER       = MaxOrderDef,
  parameter int TOP_BLOCKS      = TopBlocksDef,
  parameter int MIN_BLOCK_BYTES = MinBlockBytesDef,
  parameter int ZONES           = ZonesDef,
  localparam int MapBits = TOP_BLOCKS << MAX_ORDER,
  localparam int OW      = $clog2(MAX_ORDER + 1),
  localparam int IW      = $clog2(MapBits),
  localparam int IXW     = IW + 1,
  localparam int CNTW    = $clog2(MapBits + 1),
  localparam int HW      = IXW,
  localparam int MAW     = 1 + OW + IW,
  localparam int CAW     = 1 + OW
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind_i,
  input  logic              zone_i,
  input  logic [31:0]       address_i,
  input  logic [31:0]       size_bytes_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [31:0]       block_address_o,
  output logic [31:0]       used_bytes_o,
  output logic              map_we_o,
  output logic [MAW-1:0]    map_waddr_o,
  output logic              map_wdata_o,
  output logic [MAW-1:0]    map_raddr_o,
  input  logic              map_rdata_i,
  output logic              cnt_we_o,
  output logic [CAW-1:0]    cnt_waddr_o,
  output logic [CNTW+HW-1:0] cnt_wdata_o,
  output logic [CAW-1:0]    cnt_raddr_o,
  input  logic [CNTW+HW-1:0] cnt_rdata_i
);

  localparam int NBW    = $clog2(TOP_BLOCKS + 1);
  localparam int LogMin = $clog2(MIN_BLOCK_BYTES);
  localparam int TSh    = LogMin + MAX_ORDER;
  localparam logic [33:0] TopB   = 34'(MIN_BLOCK_BYTES) << MAX_ORDER;
  localparam logic [OW-1:0] MoW  = OW'(MAX_ORDER);
  localparam logic [IXW-1:0] LastIdx = IXW'(MapBits - 1);
  localparam logic [32:0] SpaceEnd = 33'h1_0000_0000;
  localparam bit HasZone1 = (ZONES > 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SWEEP = 4'd1;
  localparam logic [3:0] S_OP    = 4'd2;
  localparam logic [3:0] S_RZONE = 4'd3;
  localparam logic [3:0] S_RCNT  = 4'd4;
  localparam logic [3:0] S_RBIT  = 4'd5;
  localparam logic [3:0] S_RWB   = 4'd6;
  localparam logic [3:0] S_ACNT  = 4'd7;
  localparam logic [3:0] S_ASCAN = 4'd8;
  localparam logic [3:0] S_ASPL1 = 4'd9;
  localparam logic [3:0] S_ASPL2 = 4'd10;
  localparam logic [3:0] S_FCHK  = 4'd11;
  localparam logic [3:0] S_FBUD  = 4'd12;
  localparam logic [3:0] S_FBCNT = 4'd13;
  localparam logic [3:0] S_FREL  = 4'd14;
  localparam logic [3:0] S_FRCNT = 4'd15;

  function automatic logic [NBW-1:0] clamp_blocks(input logic [4:0] v);
    logic [NBW-1:0] r;
    if (9'(v) > 9'(TOP_BLOCKS)) r = NBW'(TOP_BLOCKS);
    else                        r = NBW'(v);
    return r;
  endfunction

  function automatic logic [IXW-1:0] bits_at(input logic [NBW-1:0] n, input logic [OW-1:0] o);
    return IXW'(n) << (MoW - o);
  endfunction

  function automatic logic [MAW-1:0] maddr(input logic z, input logic [OW-1:0] o,
                                           input logic [IXW-1:0] i);
    return {z, o, i[IW-1:0]};
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  logic [3:0]      state_q, state_d;
  logic [1:0]      kind_q, kind_d;
  logic            zone_q, zone_d;
  logic [31:0]     addr_q, addr_d;
  logic [31:0]     size_q, size_d;
  logic [OW-1:0]   ord_q, ord_d;
  logic [OW-1:0]   tgt_q, tgt_d;
  logic [IXW-1:0]  idx_q, idx_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [HW-1:0]   hint_q, hint_d;
  logic [IXW-1:0]  rfirst_q, rfirst_d;
  logic [IXW-1:0]  rlast_q, rlast_d;
  logic            fflag_q, fflag_d;
  logic            init_q, init_d;
  logic [NBW-1:0]  zb_q [2];
  logic [NBW-1:0]  zb_d [2];
  logic [31:0]     used_q, used_d;
  logic            done_q, done_d;
  logic [1:0]      status_q, status_d;
  logic [31:0]     baddr_q, baddr_d;

  // Derived values
  logic [NBW-1:0]  sel_zb;
  logic [IXW-1:0]  bits_w;
  logic [31:0]     zbase;
  logic [OW-1:0]   o_sz;
  logic            too_big;
  logic            zone_missing;
  logic [31:0]     f_off, f_idx;
  logic [CNTW-1:0] cnt_rd;
  logic [HW-1:0]   hint_rd;
  logic [31:0]     sz_tgt;

  // Reserve window for zone_q
  logic [32:0] r_end, r_zs, r_ze, r_lo, r_hi;
  logic [33:0] r_first, r_lp1, r_last, r_n, r_lastc;
  logic        r_ovl, r_do;
  logic [HW-1:0] r_hint;

  assign sel_zb  = zb_q[zone_q];
  assign bits_w  = bits_at(sel_zb, ord_q);
  assign zbase   = zone_q ? cfg_i.normal_zone_base : 32'd0;
  assign too_big = 34'(size_q) > TopB;
  assign zone_missing = zone_q && !HasZone1;
  assign f_off   = addr_q - zbase;
  assign f_idx   = f_off >> (LogMin + int'(o_sz));
  assign {cnt_rd, hint_rd} = cnt_rdata_i;
  assign sz_tgt  = 32'(MIN_BLOCK_BYTES) << tgt_q;

  always_comb begin
    o_sz = '0;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (33'(size_q) > (33'(MIN_BLOCK_BYTES) << k)) o_sz = OW'(k + 1);
    end
  end

  always_comb begin
    r_end   = 33'(addr_q) + 33'(size_q);
    r_zs    = zone_q ? 33'(cfg_i.normal_zone_base) : 33'd0;
    r_ze    = (zone_q || !HasZone1) ? SpaceEnd : 33'(cfg_i.normal_zone_base);
    r_ovl   = (!zone_q || HasZone1) && (r_ze > r_zs) && (r_end > r_zs)
              && (33'(addr_q) < r_ze);
    r_lo    = ((33'(addr_q) > r_zs) ? 33'(addr_q) : r_zs) - r_zs;
    r_hi    = ((r_end < r_ze) ? r_end : r_ze) - r_zs;
    r_first = 34'(r_lo) >> TSh;
    r_lp1   = (34'(r_hi) + TopB - 34'd1) >> TSh;
    r_last  = r_lp1 - 34'd1;
    r_n     = 34'(sel_zb);
    r_do    = (sel_zb != '0) && (r_first < r_n);
    r_lastc = (r_last >= r_n) ? (r_n - 34'd1) : r_last;
    r_hint  = (hint_q >= rfirst_q && hint_q <= rlast_q) ? (rlast_q + IXW'(1)) : hint_q;
  end

  always_comb begin
    state_d  = state_q;
    kind_d   = kind_q;
    zone_d   = zone_q;
    addr_d   = addr_q;
    size_d   = size_q;
    ord_d    = ord_q;
    tgt_d    = tgt_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    hint_d   = hint_q;
    rfirst_d = rfirst_q;
    rlast_d  = rlast_q;
    fflag_d  = fflag_q;
    init_d   = init_q;
    zb_d     = zb_q;
    used_d   = used_q;
    done_d   = 1'b0;
    status_d = status_q;
    baddr_d  = baddr_q;

    map_we_o    = 1'b0;
    map_waddr_o = maddr(zone_q, ord_q, idx_q);
    map_wdata_o = 1'b0;
    map_raddr_o = maddr(zone_q, ord_q, idx_q);
    cnt_we_o    = 1'b0;
    cnt_waddr_o = {zone_q, ord_q};
    cnt_wdata_o = {cnt_q, hint_q};
    cnt_raddr_o = {zone_q, ord_q};

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          kind_d  = kind_i;
          zone_d  = zone_i;
          addr_d  = address_i;
          size_d  = size_bytes_i;
          state_d = S_OP;
        end
      end

      S_SWEEP: begin
        // Rebuild: top order free up to the zone's block count, all else taken
        map_we_o    = 1'b1;
        map_wdata_o = (ord_q == MoW) ? (idx_q >= IXW'(sel_zb)) : 1'b1;
        if (idx_q == '0) begin
          cnt_we_o    = 1'b1;
          cnt_wdata_o = (ord_q == MoW) ? {CNTW'(sel_zb), HW'(0)} : {CNTW'(0), {HW{1'b1}}};
        end
        if (idx_q == LastIdx) begin
          idx_d = '0;
          if (ord_q == MoW) begin
            ord_d = '0;
            if (zone_q) begin
              zone_d = 1'b0;
              if (init_q) begin
                init_d = 1'b0;
                if (cfg_i.protect_end > cfg_i.protect_start) begin
                  addr_d  = cfg_i.protect_start;
                  size_d  = cfg_i.protect_end - cfg_i.protect_start;
                  state_d = S_RZONE;
                end else begin
                  done_d   = 1'b1;
                  status_d = ST_OK;
                  baddr_d  = '0;
                  state_d  = S_IDLE;
                end
              end else begin
                state_d = S_IDLE;
              end
            end else begin
              zone_d = 1'b1;
            end
          end else begin
            ord_d = ord_q + OW'(1);
          end
        end else begin
          idx_d = idx_q + IXW'(1);
        end
      end

      S_OP: begin
        baddr_d = '0;
        unique case (kind_q)
          KIND_ALLOC: begin
            if (too_big) begin
              done_d = 1'b1; status_d = ST_TOO_BIG; state_d = S_IDLE;
            end else if (zone_missing) begin
              done_d = 1'b1; status_d = ST_NO_FREE; state_d = S_IDLE;
            end else begin
              tgt_d       = o_sz;
              ord_d       = o_sz;
              cnt_raddr_o = {zone_q, o_sz};
              state_d     = S_ACNT;
            end
          end
          KIND_FREE: begin
            if (addr_q >= cfg_i.protect_start && addr_q < cfg_i.protect_end) begin
              done_d = 1'b1; status_d = ST_PROTECT; state_d = S_IDLE;
            end else if (zone_missing || f_idx >= 32'(bits_at(sel_zb, o_sz))) begin
              done_d = 1'b1; status_d = ST_OK; state_d = S_IDLE;
            end else begin
              tgt_d       = o_sz;
              ord_d       = o_sz;
              idx_d       = IXW'(f_idx);
              fflag_d     = 1'b1;
              map_raddr_o = maddr(zone_q, o_sz, IXW'(f_idx));
              state_d     = S_FCHK;
            end
          end
          KIND_RESERVE: begin
            if (size_q == '0) begin
              done_d = 1'b1; status_d = ST_OK; state_d = S_IDLE;
            end else begin
              zone_d  = 1'b0;
              state_d = S_RZONE;
            end
          end
          KIND_INIT: begin
            zb_d[0] = clamp_blocks(cfg_i.dma_top_blocks);
            zb_d[1] = HasZone1 ? clamp_blocks(cfg_i.normal_top_blocks) : NBW'(0);
            used_d  = '0;
            idx_d   = '0;
            ord_d   = '0;
            zone_d  = 1'b0;
            init_d  = 1'b1;
            state_d = S_SWEEP;
          end
          default: state_d = S_IDLE;
        endcase
      end

      S_RZONE: begin
        if (r_ovl) begin
          used_d = sat_add(used_q, size_q);
        end
        if (r_ovl && r_do) begin
          rfirst_d    = IXW'(r_first);
          rlast_d     = IXW'(r_lastc);
          idx_d       = IXW'(r_first);
          ord_d       = MoW;
          cnt_raddr_o = {zone_q, MoW};
          state_d     = S_RCNT;
        end else if (!zone_q) begin
          zone_d = 1'b1;
        end else begin
          done_d = 1'b1; status_d = ST_OK; baddr_d = '0; state_d = S_IDLE;
        end
      end

      S_RCNT: begin
        cnt_d       = cnt_rd;
        hint_d      = hint_rd;
        map_raddr_o = maddr(zone_q, MoW, idx_q);
        state_d     = S_RBIT;
      end

      S_RBIT: begin
        // Count only blocks that were still free
        if (!map_rdata_i) begin
          map_we_o    = 1'b1;
          map_waddr_o = maddr(zone_q, MoW, idx_q);
          map_wdata_o = 1'b1;
          cnt_d       = cnt_q - CNTW'(1);
        end
        if (idx_q == rlast_q) begin
          state_d = S_RWB;
        end else begin
          idx_d       = idx_q + IXW'(1);
          map_raddr_o = maddr(zone_q, MoW, idx_q + IXW'(1));
        end
      end

      S_RWB: begin
        cnt_we_o    = 1'b1;
        cnt_waddr_o = {zone_q, MoW};
        cnt_wdata_o = {cnt_q, r_hint};
        if (!zone_q) begin
          zone_d  = 1'b1;
          state_d = S_RZONE;
        end else begin
          done_d = 1'b1; status_d = ST_OK; baddr_d = '0; state_d = S_IDLE;
        end
      end

      S_ACNT: begin
        if (cnt_rd == '0) begin
          if (ord_q == MoW) begin
            done_d = 1'b1; status_d = ST_NO_FREE; state_d = S_IDLE;
          end else begin
            ord_d       = ord_q + OW'(1);
            cnt_raddr_o = {zone_q, ord_q + OW'(1)};
          end
        end else if (IXW'(hint_rd) >= bits_w) begin
          done_d = 1'b1; status_d = ST_NO_FREE; state_d = S_IDLE;
        end else begin
          cnt_d       = cnt_rd;
          idx_d       = IXW'(hint_rd);
          map_raddr_o = maddr(zone_q, ord_q, IXW'(hint_rd));
          state_d     = S_ASCAN;
        end
      end

      S_ASCAN: begin
        if (!map_rdata_i) begin
          map_we_o    = 1'b1;
          map_wdata_o = 1'b1;
          cnt_we_o    = 1'b1;
          cnt_wdata_o = {cnt_q - CNTW'(1), HW'(idx_q + IXW'(1))};
          if (ord_q > tgt_q) begin
            ord_d   = ord_q - OW'(1);
            idx_d   = idx_q << 1;
            state_d = S_ASPL1;
          end else begin
            done_d   = 1'b1;
            status_d = ST_OK;
            used_d   = sat_add(used_q, sz_tgt);
            baddr_d  = zbase + (32'(idx_q) << (LogMin + int'(tgt_q)));
            state_d  = S_IDLE;
          end
        end else if (idx_q + IXW'(1) >= bits_w) begin
          done_d = 1'b1; status_d = ST_NO_FREE; state_d = S_IDLE;
        end else begin
          idx_d       = idx_q + IXW'(1);
          map_raddr_o = maddr(zone_q, ord_q, idx_q + IXW'(1));
        end
      end

      S_ASPL1: begin
        // Keep the left half, fetch this order's count
        map_we_o    = 1'b1;
        map_wdata_o = 1'b1;
        state_d     = S_ASPL2;
      end

      S_ASPL2: begin
        // Free the right half
        map_we_o    = 1'b1;
        map_waddr_o = maddr(zone_q, ord_q, idx_q ^ IXW'(1));
        map_wdata_o = 1'b0;
        cnt_we_o    = 1'b1;
        cnt_wdata_o = {cnt_rd + CNTW'(1), HW'(idx_q + IXW'(1))};
        if (ord_q > tgt_q) begin
          ord_d   = ord_q - OW'(1);
          idx_d   = idx_q << 1;
          state_d = S_ASPL1;
        end else begin
          done_d   = 1'b1;
          status_d = ST_OK;
          used_d   = sat_add(used_q, sz_tgt);
          baddr_d  = zbase + (32'(idx_q) << (LogMin + int'(tgt_q)));
          state_d  = S_IDLE;
        end
      end

      S_FCHK: begin
        if (idx_q >= bits_w || !map_rdata_i) begin
          done_d = 1'b1; status_d = ST_OK; state_d = S_IDLE;
        end else begin
          if (fflag_q) begin
            used_d  = (used_q > sz_tgt) ? (used_q - sz_tgt) : 32'd0;
            fflag_d = 1'b0;
          end
          if (ord_q < MoW) begin
            map_raddr_o = maddr(zone_q, ord_q, idx_q ^ IXW'(1));
            state_d     = S_FBUD;
          end else begin
            state_d = S_FREL;
          end
        end
      end

      S_FBUD: begin
        if (!map_rdata_i) begin
          // Buddy free: take it and climb
          map_we_o    = 1'b1;
          map_waddr_o = maddr(zone_q, ord_q, idx_q ^ IXW'(1));
          map_wdata_o = 1'b1;
          state_d     = S_FBCNT;
        end else begin
          state_d = S_FREL;
        end
      end

      S_FBCNT: begin
        cnt_we_o    = 1'b1;
        cnt_wdata_o = {cnt_rd - CNTW'(1), hint_rd};
        ord_d       = ord_q + OW'(1);
        idx_d       = idx_q >> 1;
        map_raddr_o = maddr(zone_q, ord_q + OW'(1), idx_q >> 1);
        state_d     = S_FCHK;
      end

      S_FREL: begin
        map_we_o    = 1'b1;
        map_wdata_o = 1'b0;
        state_d     = S_FRCNT;
      end

      S_FRCNT: begin
        cnt_we_o    = 1'b1;
        cnt_wdata_o = {cnt_rd + CNTW'(1), (hint_rd > HW'(idx_q)) ? HW'(idx_q) : hint_rd};
        done_d      = 1'b1;
        status_d    = ST_OK;
        state_d     = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_SWEEP;
      zone_q  <= 1'b0;
      ord_q   <= '0;
      idx_q   <= '0;
      init_q  <= 1'b0;
      fflag_q <= 1'b0;
      zb_q[0] <= clamp_blocks(DMA_BLOCKS_RST);
      zb_q[1] <= HasZone1 ? clamp_blocks(NORMAL_BLOCKS_RST) : NBW'(0);
      used_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      zone_q  <= zone_d;
      ord_q   <= ord_d;
      idx_q   <= idx_d;
      init_q  <= init_d;
      fflag_q <= fflag_d;
      zb_q    <= zb_d;
      used_q  <= used_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q   <= kind_d;
    addr_q   <= addr_d;
    size_q   <= size_d;
    tgt_q    <= tgt_d;
    cnt_q    <= cnt_d;
    hint_q   <= hint_d;
    rfirst_q <= rfirst_d;
    rlast_q  <= rlast_d;
    status_q <= status_d;
    baddr_q  <= baddr_d;
  end

  assign busy            = (state_q != S_IDLE);
  assign done_o          = done_q;
  assign status_o        = status_q;
  assign block_address_o = baddr_q;
  assign used_bytes_o    = used_q;

endmodule

// ----- rtl/core/buddy_block_allocator_core.sv -----
// Buddy block allocator top level: configuration registers, bitmap RAM,
// count/hint RAM and the sequencer. Depends on bba_pkg, bba_ram, bba_engine.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its single result
// appears on status_o, block_address_o and used_bytes_o with done_o, which
// is high for exactly one cycle, and must be captured then. One request is
// worked at a time. Every step reads a RAM and then writes back, so the time
// taken is set by the bitmap bits visited: allocate reads the count of each
// order climbed, scans the bitmap from the hint and writes both halves at
// each split level; free checks the block and its buddy at each coalesce
// level; reserve marks each top block covered in each overlapped zone.
// Initialize sweeps the whole bitmap, then reserves the protected region.
// After reset the same sweep runs with busy high before the first request
// is taken; configuration writes are accepted at any time.

module buddy_block_allocator_core import bba_pkg::*; #(
  parameter int MAX_ORDER       = MaxOrderDef,
  parameter int TOP_BLOCKS      = TopBlocksDef,
  parameter int MIN_BLOCK_BYTES = MinBlockBytesDef,
  parameter int ZONES           = ZonesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind_i,
  input  logic                zone_i,
  input  logic [31:0]         address_i,
  input  logic [31:0]         size_bytes_i,
  output logic                done_o,
  output logic [1:0]          status_o,
  output logic [31:0]         block_address_o,
  output logic [31:0]         used_bytes_o
);

  localparam int MapBits = TOP_BLOCKS << MAX_ORDER;
  localparam int OW      = $clog2(MAX_ORDER + 1);
  localparam int IW      = $clog2(MapBits);
  localparam int HW      = IW + 1;
  localparam int CNTW    = $clog2(MapBits + 1);
  localparam int MAW     = 1 + OW + IW;
  localparam int CAW     = 1 + OW;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.dma_top_blocks    <= DMA_BLOCKS_RST;
      cfg_q.normal_top_blocks <= NORMAL_BLOCKS_RST;
      cfg_q.normal_zone_base  <= NORMAL_BASE_RST;
      cfg_q.protect_start     <= '0;
      cfg_q.protect_end       <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_DMA_BLOCKS:    cfg_q.dma_top_blocks    <= cfg_wdata_i[4:0];
        CFG_NORMAL_BLOCKS: cfg_q.normal_top_blocks <= cfg_wdata_i[4:0];
        CFG_NORMAL_BASE:   cfg_q.normal_zone_base  <= cfg_wdata_i;
        CFG_PROT_START:    cfg_q.protect_start     <= cfg_wdata_i;
        CFG_PROT_END:      cfg_q.protect_end       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic                 map_we, map_wdata, map_rdata;
  logic [MAW-1:0]       map_waddr, map_raddr;
  logic                 cnt_we;
  logic [CAW-1:0]       cnt_waddr, cnt_raddr;
  logic [CNTW+HW-1:0]   cnt_wdata, cnt_rdata;

  bba_ram #(
    .Width (1),
    .Depth (2 ** MAW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bba_ram #(
    .Width (CNTW + HW),
    .Depth (2 ** CAW)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (cnt_raddr),
    .rdata_o (cnt_rdata)
  );

  bba_engine #(
    .MAX_ORDER       (MAX_ORDER),
    .TOP_BLOCKS      (TOP_BLOCKS),
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .ZONES           (ZONES)
  ) u_engine (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .start           (start),
    .busy            (busy),
    .kind_i          (kind_i),
    .zone_i          (zone_i),
    .address_i       (address_i),
    .size_bytes_i    (size_bytes_i),
    .done_o          (done_o),
    .status_o        (status_o),
    .block_address_o (block_address_o),
    .used_bytes_o    (used_bytes_o),
    .map_we_o        (map_we),
    .map_waddr_o     (map_waddr),
    .map_wdata_o     (map_wdata),
    .map_raddr_o     (map_raddr),
    .map_rdata_i     (map_rdata),
    .cnt_we_o        (cnt_we),
    .cnt_waddr_o     (cnt_waddr),
    .cnt_wdata_o     (cnt_wdata),
    .cnt_raddr_o     (cnt_raddr),
    .cnt_rdata_i     (cnt_rdata)
  );

endmodule
